// ===== design/hsvtc_pkg.sv =====
// hsvtc_pkg: shared types and constants for the hsv threshold centroid unit
// no dependencies

package hsvtc_pkg;

  localparam int unsigned SumW   = 36;
  localparam int unsigned CountW = 25;
  localparam int unsigned HueW   = 13;

  typedef enum logic [2:0] {
    REG_HUE_LOW   = 3'd0,
    REG_HUE_HIGH  = 3'd1,
    REG_SAT_LOW   = 3'd2,
    REG_SAT_HIGH  = 3'd3,
    REG_VAL_LOW   = 3'd4,
    REG_VAL_HIGH  = 3'd5,
    REG_MIN_COUNT = 3'd6,
    REG_WIDTH     = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       frame_end;
  } pixel_t;

  typedef struct packed {
    logic              found;
    logic [15:0]       centroid_x;
    logic [15:0]       centroid_y;
    logic [CountW-1:0] match_count;
  } result_t;

  // frame totals handed from accumulator to divider
  typedef struct packed {
    logic [SumW-1:0]   sum_x;
    logic [SumW-1:0]   sum_y;
    logic [CountW-1:0] count;
    logic              found;
  } totals_t;

  typedef enum logic [1:0] {
    DIV_IDLE = 2'd0,
    DIV_RUN  = 2'd1,
    DIV_DONE = 2'd2
  } div_state_e;

endpackage

// ===== design/hsvtc_front.sv =====
// hsvtc_front: pipelined hsv conversion, threshold test and frame accumulation
// depends on hsvtc_pkg; hands finished frame totals to the back end

module hsvtc_front #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  hsvtc_pkg::pixel_t       in_data_i,
  input  logic [12:0]             hue_low_i,
  input  logic [12:0]             hue_high_i,
  input  logic [8:0]              sat_low_i,
  input  logic [8:0]              sat_high_i,
  input  logic [7:0]              val_low_i,
  input  logic [7:0]              val_high_i,
  input  logic [24:0]             min_count_i,
  input  logic [12:0]             width_i,
  output logic                    tot_valid_o,
  input  logic                    tot_ready_i,
  output hsvtc_pkg::totals_t      tot_o
);
  import hsvtc_pkg::*;

  localparam int unsigned ColW = $clog2(MAX_WIDTH);
  localparam int unsigned RowW = $clog2(MAX_HEIGHT);
  localparam logic [SumW-1:0]   SumLim = '1;
  localparam logic [CountW-1:0] CntLim = '1;

  // ceil(2^29 / d): exact floor division for dividends below 2^21
  typedef logic [255:0][29:0] recip_tab_t;

  function automatic recip_tab_t build_recip();
    recip_tab_t t;
    t = '0;
    for (int d = 1; d < 256; d++) begin
      t[d] = 30'(((64'd1 << 29) + 64'(d) - 64'd1) / 64'(d));
    end
    return t;
  endfunction

  localparam recip_tab_t RecipTab = build_recip();

  // stage 1: max/min, hue numerator, saturation products
  logic        s1_v_q, s2_v_q, s3_v_q;
  logic        s1_last_q, s2_last_q, s3_last_q;
  logic [7:0]  s1_mx_q, s1_diff_q;
  logic [20:0] s1_num_q;       // hue numerator in 1/16 degree units
  logic [29:0] s1_rcp_q;
  logic [16:0] s1_dsh_q;
  logic [16:0] s1_slo_q, s1_shi_q;
  logic        s1_zero_q;

  logic        stall;
  assign stall = s3_v_q && s3_last_q && tot_valid_o && !tot_ready_i;
  assign in_ready_o = !stall;

  logic [7:0] r, g, b, mx, mn, df;
  logic [10:0] nb;
  logic [20:0] xn;
  always_comb begin
    r = in_data_i.red; g = in_data_i.green; b = in_data_i.blue;
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    df = mx - mn;
    if (mx == r) begin
      if (g >= b) nb = {3'd0, g - b};
      else nb = 11'(6 * df) - 11'(b - g);
    end else if (mx == g) begin
      nb = 11'(2 * df) + 11'(b) - 11'(r);
    end else begin
      nb = 11'(4 * df) + 11'(r) - 11'(g);
    end
    xn = 21'(nb) * 21'd960;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (!stall) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall) begin
      s1_last_q <= in_data_i.frame_end;
      s1_mx_q   <= mx;
      s1_diff_q <= df;
      s1_num_q  <= xn;
      s1_rcp_q  <= RecipTab[df];
      s1_dsh_q  <= {1'b0, df, 8'd0};
      s1_slo_q  <= 17'(sat_low_i) * 17'(mx);
      s1_shi_q  <= 17'(sat_high_i) * 17'(mx);
      s1_zero_q <= (mx == 8'd0);
    end
  end

  // stage 2: hue = num / diff by reciprocal multiply
  logic [50:0] hprod;
  always_comb begin
    hprod = 51'(s1_num_q) * 51'(s1_rcp_q);
  end

  logic [12:0] s2_hue_q;
  logic        s2_ok_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_v_q <= 1'b0;
    else if (!stall) s2_v_q <= s1_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (!stall) begin
      s2_last_q <= s1_last_q;
      s2_hue_q  <= (s1_diff_q == 8'd0) ? 13'd0 : hprod[41:29];
      s2_ok_q   <= (s1_mx_q >= val_low_i) && (s1_mx_q <= val_high_i) &&
                   (s1_zero_q ? (sat_low_i == 9'd0) :
                    (s1_dsh_q >= s1_slo_q && s1_dsh_q <= s1_shi_q));
    end
  end

  // stage 3: final match flag
  logic s3_hit_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_v_q <= 1'b0;
    else if (!stall) s3_v_q <= s2_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (!stall) begin
      s3_last_q <= s2_last_q;
      s3_hit_q  <= s2_ok_q && s2_hue_q >= hue_low_i && s2_hue_q <= hue_high_i;
    end
  end

  // accumulate
  logic [ColW-1:0]   col_q;
  logic [RowW-1:0]   row_q;
  logic [SumW-1:0]   sx_q, sy_q;
  logic [CountW-1:0] cnt_q;
  logic [SumW:0]     sx_n, sy_n;
  logic [SumW-1:0]   sx_s, sy_s;
  logic [CountW-1:0] cnt_s;
  logic [14:0]       wcl;

  always_comb begin
    sx_n = {1'b0, sx_q} + (SumW + 1)'(col_q);
    sy_n = {1'b0, sy_q} + (SumW + 1)'(row_q);
    sx_s = sx_q; sy_s = sy_q; cnt_s = cnt_q;
    if (s3_hit_q) begin
      sx_s = sx_n[SumW] ? SumLim : sx_n[SumW-1:0];
      sy_s = sy_n[SumW] ? SumLim : sy_n[SumW-1:0];
      if (cnt_q != CntLim) cnt_s = cnt_q + 1'b1;
    end
    wcl = 15'(width_i);
    if (wcl == 15'd0) wcl = 15'd1;
    if (wcl > 15'(MAX_WIDTH)) wcl = 15'(MAX_WIDTH);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0; row_q <= '0; sx_q <= '0; sy_q <= '0; cnt_q <= '0;
      tot_valid_o <= 1'b0;
    end else begin
      if (tot_valid_o && tot_ready_i) tot_valid_o <= 1'b0;
      if (s3_v_q && !stall) begin
        if (s3_last_q) begin
          tot_valid_o <= 1'b1;
          tot_o.sum_x <= sx_s;
          tot_o.sum_y <= sy_s;
          tot_o.count <= cnt_s;
          tot_o.found <= cnt_s >= min_count_i;
          col_q <= '0; row_q <= '0; sx_q <= '0; sy_q <= '0; cnt_q <= '0;
        end else begin
          sx_q <= sx_s; sy_q <= sy_s; cnt_q <= cnt_s;
          if (15'(col_q) + 15'd1 >= wcl) begin
            col_q <= '0;
            if (32'(row_q) + 32'd1 < MAX_HEIGHT) row_q <= row_q + 1'b1;
          end else begin
            col_q <= col_q + 1'b1;
          end
        end
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |-> tot_valid_o) else $error("stall without pending totals");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_v_q && s3_last_q && !stall) |=> (tot_valid_o && col_q == '0 && cnt_q == '0))
    else $error("frame end did not clear state");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tot_valid_o && !tot_ready_i) |=> $stable(tot_o)) else $error("totals changed");

endmodule

// ===== design/hsvtc_back.sv =====
// hsvtc_back: serial centroid divider and result output register
// depends on hsvtc_pkg; takes frame totals from the front end

module hsvtc_back #(
  parameter int unsigned FRAC = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               tot_valid_i,
  output logic               tot_ready_o,
  input  hsvtc_pkg::totals_t tot_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output hsvtc_pkg::result_t out_data_o
);
  import hsvtc_pkg::*;

  localparam int unsigned NW = SumW + FRAC;
  localparam int unsigned CW = $clog2(NW + 1);

  div_state_e st_q, st_d;
  logic [NW-1:0]     nx_q, ny_q;
  logic [CountW:0]   rx_q, ry_q;
  logic [CountW-1:0] dv_q;
  logic              fd_q;
  logic [CW-1:0]     bit_q;

  logic [CountW:0] rx_t, ry_t;
  logic            qx, qy;
  always_comb begin
    rx_t = {rx_q[CountW-1:0], nx_q[NW-1]};
    ry_t = {ry_q[CountW-1:0], ny_q[NW-1]};
    qx = rx_t >= {1'b0, dv_q};
    qy = ry_t >= {1'b0, dv_q};
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      DIV_IDLE: if (tot_valid_i) st_d = DIV_RUN;
      DIV_RUN:  if (bit_q == CW'(NW - 1)) st_d = DIV_DONE;
      DIV_DONE: if (!out_valid_o || out_ready_i) st_d = DIV_IDLE;
      default:  st_d = DIV_IDLE;
    endcase
  end

  always_comb begin
    tot_ready_o = (st_q == DIV_IDLE);
  end

  function automatic logic [15:0] sat16(input logic [NW-1:0] v);
    sat16 = (v > NW'(16'hFFFF)) ? 16'hFFFF : v[15:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= DIV_IDLE;
      out_valid_o <= 1'b0;
    end else begin
      st_q <= st_d;
      if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      if (st_q == DIV_DONE && (!out_valid_o || out_ready_i)) out_valid_o <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      DIV_IDLE: begin
        nx_q <= NW'(tot_i.sum_x) << FRAC;
        ny_q <= NW'(tot_i.sum_y) << FRAC;
        rx_q <= '0; ry_q <= '0;
        dv_q <= tot_i.count;
        fd_q <= tot_i.found;
        bit_q <= '0;
      end
      DIV_RUN: begin
        // quotient bits shift into the low end of the numerator
        rx_q <= qx ? rx_t - {1'b0, dv_q} : rx_t;
        ry_q <= qy ? ry_t - {1'b0, dv_q} : ry_t;
        nx_q <= {nx_q[NW-2:0], qx};
        ny_q <= {ny_q[NW-2:0], qy};
        bit_q <= bit_q + 1'b1;
      end
      DIV_DONE: begin
        if (!out_valid_o || out_ready_i) begin
          out_data_o.found       <= fd_q;
          out_data_o.centroid_x  <= (fd_q && dv_q != '0) ? sat16(nx_q) : 16'd0;
          out_data_o.centroid_y  <= (fd_q && dv_q != '0) ? sat16(ny_q) : 16'd0;
          out_data_o.match_count <= dv_q;
        end
      end
      default: ;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == DIV_RUN) |-> !tot_ready_o) else $error("ready while dividing");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tot_valid_i && tot_ready_o) |=> (st_q == DIV_RUN)) else $error("divide not started");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(out_data_o)) else $error("result changed");

endmodule

// ===== design/hsv_threshold_centroid_unit.sv =====
// hsv_threshold_centroid_unit: one pixel per cycle, three-stage classification pipe
// result path: classification pipe, frame accumulator, then a serial divider
// throughput: one pixel per cycle; a frame end stalls input only while the previous
// frame's totals still wait for the divider to take them
// reset: asynchronous active-low, clears counters, sums, valids; config to defaults
// depends on hsvtc_pkg, hsvtc_front, hsvtc_back

module hsv_threshold_centroid_unit #(
  parameter int unsigned MAX_WIDTH          = 4096,
  parameter int unsigned MAX_HEIGHT         = 4096,
  parameter int unsigned CENTROID_FRAC_BITS = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  hsvtc_pkg::pixel_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output hsvtc_pkg::result_t out_data_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [24:0]        cfg_data_i
);
  import hsvtc_pkg::*;

  logic [12:0] hue_lo_q, hue_hi_q, width_q;
  logic [8:0]  sat_lo_q, sat_hi_q;
  logic [7:0]  val_lo_q, val_hi_q;
  logic [24:0] min_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_lo_q <= 13'd560; hue_hi_q <= 13'd1360;
      sat_lo_q <= 9'd102;  sat_hi_q <= 9'd256;
      val_lo_q <= 8'd51;   val_hi_q <= 8'd255;
      min_q    <= 25'd20;  width_q  <= 13'd640;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_HUE_LOW:   hue_lo_q <= cfg_data_i[12:0];
        REG_HUE_HIGH:  hue_hi_q <= cfg_data_i[12:0];
        REG_SAT_LOW:   sat_lo_q <= cfg_data_i[8:0];
        REG_SAT_HIGH:  sat_hi_q <= cfg_data_i[8:0];
        REG_VAL_LOW:   val_lo_q <= cfg_data_i[7:0];
        REG_VAL_HIGH:  val_hi_q <= cfg_data_i[7:0];
        REG_MIN_COUNT: min_q    <= cfg_data_i;
        REG_WIDTH:     width_q  <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  logic    tot_valid, tot_ready;
  totals_t tot;

  hsvtc_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .hue_low_i(hue_lo_q), .hue_high_i(hue_hi_q),
    .sat_low_i(sat_lo_q), .sat_high_i(sat_hi_q),
    .val_low_i(val_lo_q), .val_high_i(val_hi_q),
    .min_count_i(min_q), .width_i(width_q),
    .tot_valid_o(tot_valid), .tot_ready_i(tot_ready), .tot_o(tot)
  );

  hsvtc_back #(.FRAC(CENTROID_FRAC_BITS)) u_back (
    .clk_i, .rst_ni,
    .tot_valid_i(tot_valid), .tot_ready_o(tot_ready), .tot_i(tot),
    .out_valid_o, .out_ready_i, .out_data_o
  );

endmodule

// ===== tb/hsvtc_checker.sv =====
// hsvtc_checker: watches the pixel, result and register ports of the centroid unit,
// predicts each frame result and compares it field by field; depends on hsvtc_pkg
`timescale 1ns / 100ps

module hsvtc_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  hsvtc_pkg::pixel_t  in_data_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  hsvtc_pkg::result_t out_data_i,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [24:0]        cfg_data_i,
  output int                 errors_o,
  output int                 pending_o
);
  import hsvtc_pkg::*;

  localparam longint unsigned SumMax   = (64'd1 << 36) - 1;
  localparam longint unsigned CountMax = (64'd1 << 25) - 1;

  logic [12:0] hue_lo, hue_hi, width_cfg;
  logic [8:0]  sat_lo, sat_hi;
  logic [7:0]  val_lo, val_hi;
  logic [24:0] min_cnt;

  longint unsigned col, row, sum_x, sum_y, hits;
  result_t frame_results_q[$];

  function automatic int unsigned hue_sixteenths(int unsigned r, int unsigned g,
                                                 int unsigned b, int unsigned mx,
                                                 int unsigned diff);
    int unsigned num;
    if (diff == 0) return 0;
    if (mx == r) begin
      if (g >= b) num = 960 * (g - b);
      else num = 960 * (6 * diff - (b - g));
    end else if (mx == g) begin
      num = 960 * (2 * diff + b - r);
    end else begin
      num = 960 * (4 * diff + r - g);
    end
    return num / diff;
  endfunction

  function automatic logic [15:0] mean_q4(longint unsigned s, longint unsigned c);
    longint unsigned q;
    if (c == 0) return 16'd0;
    q = (s << 4) / c;
    return (q > 65535) ? 16'hffff : q[15:0];
  endfunction

  task automatic absorb_pixel(input pixel_t p);
    int unsigned r, g, b, mx, mn, diff, h;
    longint unsigned w;
    logic in_h, in_s, in_v;
    result_t res;
    r = p.red; g = p.green; b = p.blue;
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    diff = mx - mn;
    h = hue_sixteenths(r, g, b, mx, diff);
    in_v = (mx >= val_lo) && (mx <= val_hi);
    if (mx == 0) in_s = (sat_lo == 0);
    else in_s = (diff * 256 >= sat_lo * mx) && (diff * 256 <= sat_hi * mx);
    in_h = (h >= hue_lo) && (h <= hue_hi);
    if (in_h && in_s && in_v) begin
      sum_x = (sum_x + col > SumMax) ? SumMax : sum_x + col;
      sum_y = (sum_y + row > SumMax) ? SumMax : sum_y + row;
      if (hits < CountMax) hits++;
    end
    if (p.frame_end) begin
      res.found       = (hits >= min_cnt);
      res.centroid_x  = res.found ? mean_q4(sum_x, hits) : 16'd0;
      res.centroid_y  = res.found ? mean_q4(sum_y, hits) : 16'd0;
      res.match_count = hits[24:0];
      frame_results_q.push_back(res);
      col = 0; row = 0; sum_x = 0; sum_y = 0; hits = 0;
    end else begin
      w = width_cfg;
      if (w == 0) w = 1;
      if (w > 4096) w = 4096;
      if (col + 1 >= w) begin
        col = 0;
        if (row + 1 < 4096) row++;
      end else begin
        col++;
      end
    end
  endtask

  task automatic compare_result(input result_t got);
    result_t want;
    if (frame_results_q.size() == 0) begin
      $error("result beat with no frame pending");
      errors_o++;
      return;
    end
    want = frame_results_q.pop_front();
    if (got.found !== want.found) begin
      $error("found: expected %0d, got %0d", want.found, got.found);
      errors_o++;
    end
    if (got.centroid_x !== want.centroid_x) begin
      $error("centroid_x: expected %0d, got %0d", want.centroid_x, got.centroid_x);
      errors_o++;
    end
    if (got.centroid_y !== want.centroid_y) begin
      $error("centroid_y: expected %0d, got %0d", want.centroid_y, got.centroid_y);
      errors_o++;
    end
    if (got.match_count !== want.match_count) begin
      $error("match_count: expected %0d, got %0d", want.match_count, got.match_count);
      errors_o++;
    end
  endtask

  initial begin
    errors_o  = 0;
    pending_o = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_lo = 13'd560; hue_hi = 13'd1360;
      sat_lo = 9'd102;  sat_hi = 9'd256;
      val_lo = 8'd51;   val_hi = 8'd255;
      min_cnt = 25'd20; width_cfg = 13'd640;
      col = 0; row = 0; sum_x = 0; sum_y = 0; hits = 0;
    end else begin
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_HUE_LOW:   hue_lo    = cfg_data_i[12:0];
          REG_HUE_HIGH:  hue_hi    = cfg_data_i[12:0];
          REG_SAT_LOW:   sat_lo    = cfg_data_i[8:0];
          REG_SAT_HIGH:  sat_hi    = cfg_data_i[8:0];
          REG_VAL_LOW:   val_lo    = cfg_data_i[7:0];
          REG_VAL_HIGH:  val_hi    = cfg_data_i[7:0];
          REG_MIN_COUNT: min_cnt   = cfg_data_i;
          REG_WIDTH:     width_cfg = cfg_data_i[12:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) absorb_pixel(in_data_i);
      if (out_valid_i && out_ready_i) compare_result(out_data_i);
      pending_o = frame_results_q.size();
    end
  end

endmodule

// ===== tb/hsv_threshold_centroid_unit_test.sv =====
// hsv_threshold_centroid_unit_test: drives pixel frames and register settings into
// the centroid unit; depends on hsvtc_pkg, hsvtc_checker and the unit itself
`timescale 1ns / 100ps

module hsv_threshold_centroid_unit_test;
  import hsvtc_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  pixel_t      in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  result_t     out_data_o;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [24:0] cfg_data_i = '0;

  int errors, pending;
  int pixels_sent;
  int idle_cycles;
  logic calm_in;

  hsv_threshold_centroid_unit u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  hsvtc_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_data_i(out_data_o),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .errors_o(errors), .pending_o(pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // no beat on either side for too long means the block hung
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= 20000) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // result side: random stalls, calm stretches, and one long hold-off
  initial begin : result_sink
    int got;
    logic held, calm;
    got = 0; held = 1'b0; calm = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) got++;
      if ($urandom_range(0, 49) == 0) calm = ~calm;
      if (!held && got >= 10) begin
        out_ready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
        held = 1'b1;
      end else if (!calm && $urandom_range(0, 39) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(15, 60)) @(posedge clk_i);
      end else begin
        out_ready_i <= calm ? 1'b1 : ($urandom_range(0, 3) != 0);
      end
    end
  end

  task automatic send_pixel(input logic [7:0] r, g, b, input logic last);
    int gap;
    pixel_t p;
    p.red = r; p.green = g; p.blue = b; p.frame_end = last;
    if (calm_in) gap = 0;
    else if ($urandom_range(0, 19) == 0) gap = $urandom_range(10, 40);
    else gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= p;
    do @(posedge clk_i); while (!in_ready_o);
    pixels_sent++;
  endtask

  // let every frame result drain, then give the divider time to settle
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [24:0] v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
  endtask

  task automatic program_all(input int hl, hh, sl, sh, vl, vh, mc, w);
    @(posedge clk_i);
    write_reg(REG_HUE_LOW, 25'(hl));
    write_reg(REG_HUE_HIGH, 25'(hh));
    write_reg(REG_SAT_LOW, 25'(sl));
    write_reg(REG_SAT_HIGH, 25'(sh));
    write_reg(REG_VAL_LOW, 25'(vl));
    write_reg(REG_VAL_HIGH, 25'(vh));
    write_reg(REG_MIN_COUNT, 25'(mc));
    write_reg(REG_WIDTH, 25'(w));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_frames(input int quota);
    int start, len, k;
    logic [7:0] r, g, b;
    start = pixels_sent;
    while (pixels_sent - start < quota) begin
      calm_in = ($urandom_range(0, 3) == 0);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 24);
      for (k = 0; k < len; k++) begin
        r = 8'($urandom_range(0, 255));
        g = 8'($urandom_range(0, 255));
        b = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 9))
          0: begin g = r; b = r; end
          1: begin r = 0; g = 0; b = 0; end
          2: begin r = 8'hff; b = 8'($urandom_range(0, 40)); end
          default: ;
        endcase
        send_pixel(r, g, b, k == len - 1);
      end
    end
  endtask

  initial begin : stimulus
    int ph, hl, sl;
    pixels_sent = 0; idle_cycles = 0; calm_in = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset settings: black, grey, white, primaries, hue wrap, channel ties
    send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd128, 8'd128, 8'd128, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd255, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd255, 1'b0);
    send_pixel(8'd255, 8'd0, 8'd128, 1'b0);
    send_pixel(8'd200, 8'd200, 8'd10, 1'b0);
    send_pixel(8'd10, 8'd200, 8'd200, 1'b0);
    send_pixel(8'd255, 8'd170, 8'd0, 1'b0);
    send_pixel(8'd255, 8'd200, 8'd0, 1'b0);
    send_pixel(8'd60, 8'd50, 8'd0, 1'b1);
    settle();

    // accept everything, width one, no minimum; lone black pixel frame
    program_all(0, 5760, 0, 256, 0, 255, 0, 1);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
    send_pixel(8'd1, 8'd254, 8'd127, 1'b0);
    send_pixel(8'd254, 8'd1, 8'd128, 1'b1);
    random_frames(150);
    settle();

    // nothing matches but minimum is zero: found with zero centroids
    program_all(5760, 5760, 256, 256, 255, 255, 0, 4096);
    send_pixel(8'd255, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
    random_frames(150);
    settle();

    program_all(0, 5760, 0, 256, 0, 255, 16777216, 0);
    random_frames(150);
    settle();

    program_all(0, 5760, 0, 256, 0, 255, 1, 8191);
    random_frames(150);
    settle();

    for (ph = 0; ph < 5; ph++) begin
      hl = $urandom_range(0, 3000);
      sl = $urandom_range(0, 200);
      program_all(hl, hl + $urandom_range(0, 5760 - hl), sl, sl + $urandom_range(0, 256 - sl),
                  $urandom_range(0, 100), $urandom_range(100, 255), $urandom_range(0, 8),
                  $urandom_range(1, 20));
      random_frames(150);
      settle();
    end

    if (errors == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
